/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the circumcenter block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in every cycle in which ante holds.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Check that cond never holds.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

/* design/ccc_pkg.sv */
// ----------------------------------------------------------------------------
// ccc_pkg
// Widths, types and latencies shared by the circumcenter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ccc_pkg;

   localparam int CW    = 16;          // input coordinate, Q8.8
   localparam int DFW   = CW + 1;      // coordinate difference
   localparam int SQW   = 32;          // one squared difference
   localparam int LW    = 34;          // squared edge length
   localparam int FW    = 36;          // weight factor (sum of two minus one)
   localparam int WW    = 70;          // vertex weight
   localparam int PW    = WW + CW;     // weight times coordinate
   localparam int DENW  = 72;          // weight sum
   localparam int NUMW  = 88;          // weighted coordinate sum
   localparam int NAW   = NUMW - 1;    // magnitude of that sum
   localparam int NW    = NAW + 2;     // dividend 2|n| + |d|
   localparam int DW    = DENW + 1;    // divisor 2|d|
   localparam int RW    = DW + 1;      // partial remainder
   localparam int QB    = 33;          // quotient bits developed
   localparam int OW    = 32;          // result coordinate, Q24.8

   localparam int FRONT_LAT = 3;
   localparam int NUMER_LAT = 4;
   localparam int DIV_LAT   = QB + 2;
   localparam int RSP_LAT   = 1 + FRONT_LAT + NUMER_LAT + DIV_LAT + 1;

   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_2D    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESET = 2'd3;

   localparam logic signed [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
   localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      logic valid;
      logic is2d;
   } ctrl_type;

   typedef struct packed {
      logic is2d;
      logic deg;
   } tag_type;

endpackage

`default_nettype wire

/* design/triangle_circumcenter_core.sv */
// ----------------------------------------------------------------------------
// triangle_circumcenter_core
// Streaming triangle circumcenter from barycentric weights, Q8.8 in, Q24.8 out.
// ----------------------------------------------------------------------------
// A triangle beat is taken on every clock edge where start is high; busy is
// tied low, so a new triangle may be offered in every cycle and the block
// sustains one triangle per clock. Each result appears on the rsp_ ports for
// exactly one cycle, marked by rsp_valid, and in request order; the receiver
// cannot stall, so it must capture every strobed beat. Each of the three
// coordinates runs through its own pipelined restoring divider that
// develops one quotient bit per stage over 33 stages. Ahead of it sit one
// input register, three stages for edge lengths and weights and four for the
// weighted sums and the rounding offset, and one output register follows.
// Results are rounded to nearest, ties away from zero, and clamped to signed
// 32 bits with rsp_saturated raised. A zero weight sum returns zero
// coordinates with rsp_degenerate set. Writing 2 to the mode register selects
// 2D operation (z ignored, center z reported as zero); any other value is 3D.
// Write the mode only while no triangle is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_circumcenter_core import ccc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [CW-1:0]    req_a_x,
   input  logic signed [CW-1:0]    req_a_y,
   input  logic signed [CW-1:0]    req_a_z,
   input  logic signed [CW-1:0]    req_b_x,
   input  logic signed [CW-1:0]    req_b_y,
   input  logic signed [CW-1:0]    req_b_z,
   input  logic signed [CW-1:0]    req_c_x,
   input  logic signed [CW-1:0]    req_c_y,
   input  logic signed [CW-1:0]    req_c_z,
   input  logic                    csr_write_en,
   input  logic [MODE_W-1:0]       csr_write_data,
   output logic                    rsp_valid,
   output logic signed [OW-1:0]    rsp_center_x,
   output logic signed [OW-1:0]    rsp_center_y,
   output logic signed [OW-1:0]    rsp_center_z,
   output logic                    rsp_degenerate,
   output logic                    rsp_saturated
);

   logic [MODE_W-1:0]    mode_ff;
   ctrl_type             in_ctl_ff;
   coord_type            in_v_ff [3][3];

   ctrl_type             fr_ctl;
   coord_type            fr_v [3][3];
   logic signed [WW-1:0] fr_w [3];

   logic                 nm_valid;
   tag_type              nm_tag;
   logic [NW-1:0]        nm_n [3];
   logic [DW-1:0]        nm_d;
   logic                 nm_neg [3];

   logic                 dv_valid [3];
   logic signed [OW-1:0] dv_q [3];
   logic                 dv_sat [3];

   tag_type              tag_ff [DIV_LAT];
   tag_type              tag_out;

   logic                 rsp_valid_ff;
   logic signed [OW-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                 rsp_deg_ff, rsp_sat_ff;

   // The pipeline never refuses a beat.
   assign busy = 1'b0;

   // Mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else if (csr_write_en) begin
         mode_ff <= csr_write_data;
      end
   end

   // Input register: capture the beat and the mode it runs under.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctl_ff <= '0;
      end else begin
         in_ctl_ff.valid <= start && !busy;
         in_ctl_ff.is2d  <= (mode_ff == MODE_2D);
      end
   end

   always_ff @(posedge clock) begin
      in_v_ff[0][0] <= req_a_x;
      in_v_ff[0][1] <= req_a_y;
      in_v_ff[0][2] <= req_a_z;
      in_v_ff[1][0] <= req_b_x;
      in_v_ff[1][1] <= req_b_y;
      in_v_ff[1][2] <= req_b_z;
      in_v_ff[2][0] <= req_c_x;
      in_v_ff[2][1] <= req_c_y;
      in_v_ff[2][2] <= req_c_z;
   end

   // Edge lengths and weights.
   ccc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (in_ctl_ff),
      .in_v    (in_v_ff),
      .out_ctl (fr_ctl),
      .out_v   (fr_v),
      .out_w   (fr_w)
   );

   // Weighted sums, weight sum, dividend and divisor.
   ccc_numer u_numer (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (fr_ctl),
      .in_v      (fr_v),
      .in_w      (fr_w),
      .out_valid (nm_valid),
      .out_tag   (nm_tag),
      .out_n     (nm_n),
      .out_d     (nm_d),
      .out_neg   (nm_neg)
   );

   // One divider per coordinate, all sharing the divisor.
   for (genvar i = 0; i < 3; i++) begin : g_div
      ccc_div u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (nm_valid),
         .in_n      (nm_n[i]),
         .in_d      (nm_d),
         .in_neg    (nm_neg[i]),
         .out_valid (dv_valid[i]),
         .out_q     (dv_q[i]),
         .out_sat   (dv_sat[i])
      );
   end

   // Hold the mode and degenerate flags alongside the divider beats.
   always_ff @(posedge clock) begin
      tag_ff[0] <= nm_tag;
      for (int s = 1; s < DIV_LAT; s++) begin
         tag_ff[s] <= tag_ff[s-1];
      end
   end

   assign tag_out = tag_ff[DIV_LAT-1];

   // Output register: drop coordinates on a degenerate triangle, drop z in 2D.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_valid[0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_deg_ff <= tag_out.deg;
      if (tag_out.deg) begin
         rsp_x_ff   <= '0;
         rsp_y_ff   <= '0;
         rsp_z_ff   <= '0;
         rsp_sat_ff <= 1'b0;
      end else begin
         rsp_x_ff   <= dv_q[0];
         rsp_y_ff   <= dv_q[1];
         rsp_z_ff   <= tag_out.is2d ? '0 : dv_q[2];
         rsp_sat_ff <= dv_sat[0] || dv_sat[1] || (dv_sat[2] && !tag_out.is2d);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_center_x   = rsp_x_ff;
   assign rsp_center_y   = rsp_y_ff;
   assign rsp_center_z   = rsp_z_ff;
   assign rsp_degenerate = rsp_deg_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule

`default_nettype wire

/* design/ccc_front.sv */
// ----------------------------------------------------------------------------
// ccc_front
// Squared edge lengths and vertex weights, three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ccc_front import ccc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_type               in_ctl,
   input  coord_type              in_v [3][3],
   output ctrl_type               out_ctl,
   output coord_type              out_v [3][3],
   output logic signed [WW-1:0]   out_w [3]
);

   logic signed [DFW-1:0]   dif [3][3];
   logic signed [2*DFW-1:0] sqp [3][3];
   logic [SQW-1:0]          sq_in [3][3];
   logic [SQW-1:0]          sq_ff [3][3];
   logic [LW-1:0]           len_in [3];
   logic [LW-1:0]           len_ff [3];
   logic signed [FW-1:0]    fac_in [3];
   logic signed [FW-1:0]    fac_ff [3];
   logic signed [LW+FW:0]   wp [3];
   logic signed [WW-1:0]    w_in [3];
   logic signed [WW-1:0]    w_ff [3];
   coord_type               v_a_ff [3][3];
   coord_type               v_b_ff [3][3];
   coord_type               v_c_ff [3][3];
   ctrl_type                ctl_a_ff, ctl_b_ff, ctl_c_ff;

   // Edge 0 is opposite vertex A, edge 1 opposite B, edge 2 opposite C.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dif[0][i] = DFW'(in_v[1][i]) - DFW'(in_v[2][i]);
         dif[1][i] = DFW'(in_v[2][i]) - DFW'(in_v[0][i]);
         dif[2][i] = DFW'(in_v[0][i]) - DFW'(in_v[1][i]);
         if (in_ctl.is2d && (i == 2)) begin
            dif[0][i] = '0;
            dif[1][i] = '0;
            dif[2][i] = '0;
         end
         for (int e = 0; e < 3; e++) begin
            sqp[e][i]   = dif[e][i] * dif[e][i];
            sq_in[e][i] = sqp[e][i][SQW-1:0];
         end
      end
   end

   always_comb begin
      for (int e = 0; e < 3; e++) begin
         len_in[e] = LW'(sq_ff[e][0]) + LW'(sq_ff[e][1]) + LW'(sq_ff[e][2]);
      end
      fac_in[0] = $signed(FW'(len_in[1]) + FW'(len_in[2]) - FW'(len_in[0]));
      fac_in[1] = $signed(FW'(len_in[0]) + FW'(len_in[2]) - FW'(len_in[1]));
      fac_in[2] = $signed(FW'(len_in[0]) + FW'(len_in[1]) - FW'(len_in[2]));
   end

   always_comb begin
      for (int e = 0; e < 3; e++) begin
         wp[e]   = $signed({1'b0, len_ff[e]}) * fac_ff[e];
         w_in[e] = wp[e][WW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         ctl_c_ff <= '0;
      end else begin
         ctl_a_ff <= in_ctl;
         ctl_b_ff <= ctl_a_ff;
         ctl_c_ff <= ctl_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff  <= sq_in;
      len_ff <= len_in;
      fac_ff <= fac_in;
      w_ff   <= w_in;
      v_a_ff <= in_v;
      v_b_ff <= v_a_ff;
      v_c_ff <= v_b_ff;
   end

   assign out_ctl = ctl_c_ff;
   assign out_v   = v_c_ff;
   assign out_w   = w_ff;

endmodule

`default_nettype wire

/* design/ccc_numer.sv */
// ----------------------------------------------------------------------------
// ccc_numer
// Weighted sums, weight sum and unsigned dividend/divisor, four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ccc_numer import ccc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_type               in_ctl,
   input  coord_type              in_v [3][3],
   input  logic signed [WW-1:0]   in_w [3],
   output logic                   out_valid,
   output tag_type                out_tag,
   output logic [NW-1:0]          out_n [3],
   output logic [DW-1:0]          out_d,
   output logic                   out_neg [3]
);

   logic signed [PW-1:0]   p_in [3][3];
   logic signed [PW-1:0]   p_ff [3][3];
   logic signed [DENW-1:0] den_in, den_ff;
   logic signed [NUMW-1:0] num_in [3];
   logic signed [NUMW-1:0] num_ff [3];
   logic [DENW-1:0]        dabs_in, dabs_e_ff, dabs_f_ff;
   logic                   dneg_in, dneg_ff;
   logic                   deg_in;
   logic [NAW-1:0]         nabs_in [3];
   logic [NAW-1:0]         nabs_ff [3];
   logic                   neg_in [3];
   logic                   neg_f_ff [3];
   logic                   neg_g_ff [3];
   logic [DW-1:0]          d_f_ff, d_g_ff;
   logic [NW-1:0]          n_in [3];
   logic [NW-1:0]          n_ff [3];
   logic [NUMER_LAT-1:0]   vld_ff;
   logic                   is2d_d_ff, is2d_e_ff, is2d_f_ff, is2d_g_ff;
   logic                   deg_e_ff, deg_f_ff, deg_g_ff;

   // Stage D: per-vertex products and the weight sum.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            p_in[k][i] = in_w[k] * in_v[k][i];
         end
      end
      den_in = DENW'(in_w[0]) + DENW'(in_w[1]) + DENW'(in_w[2]);
   end

   // Stage E: coordinate sums, divisor magnitude.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_in[i] = NUMW'(p_ff[0][i]) + NUMW'(p_ff[1][i]) + NUMW'(p_ff[2][i]);
      end
      deg_in  = (den_ff == '0);
      dneg_in = den_ff[DENW-1];
      dabs_in = dneg_in ? DENW'(-den_ff) : DENW'(den_ff);
   end

   // Stage F: numerator magnitude and quotient sign.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nabs_in[i] = num_ff[i][NUMW-1] ? NAW'(-num_ff[i]) : NAW'(num_ff[i]);
         neg_in[i]  = num_ff[i][NUMW-1] ^ dneg_ff;
      end
   end

   // Stage G: fold the half-divisor rounding offset into the dividend.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i] = NW'({nabs_ff[i], 1'b0}) + NW'(dabs_f_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NUMER_LAT-2:0], in_ctl.valid};
      end
   end

   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      den_ff    <= den_in;
      is2d_d_ff <= in_ctl.is2d;
      num_ff    <= num_in;
      dabs_e_ff <= dabs_in;
      dneg_ff   <= dneg_in;
      deg_e_ff  <= deg_in;
      is2d_e_ff <= is2d_d_ff;
      nabs_ff   <= nabs_in;
      neg_f_ff  <= neg_in;
      dabs_f_ff <= dabs_e_ff;
      d_f_ff    <= {dabs_e_ff, 1'b0};
      deg_f_ff  <= deg_e_ff;
      is2d_f_ff <= is2d_e_ff;
      n_ff      <= n_in;
      neg_g_ff  <= neg_f_ff;
      d_g_ff    <= d_f_ff;
      deg_g_ff  <= deg_f_ff;
      is2d_g_ff <= is2d_f_ff;
   end

   assign out_valid    = vld_ff[NUMER_LAT-1];
   assign out_tag.is2d = is2d_g_ff;
   assign out_tag.deg  = deg_g_ff;
   assign out_n        = n_ff;
   assign out_d        = d_g_ff;
   assign out_neg      = neg_g_ff;

endmodule

`default_nettype wire

/* design/ccc_div.sv */
// ----------------------------------------------------------------------------
// ccc_div
// Pipelined restoring divider, one quotient bit per stage, with rounding
// sign fix-up and saturation to a signed result.
// ----------------------------------------------------------------------------
`default_nettype none

module ccc_div import ccc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [NW-1:0]        in_n,
   input  logic [DW-1:0]        in_d,
   input  logic                 in_neg,
   output logic                 out_valid,
   output logic signed [OW-1:0] out_q,
   output logic                 out_sat
);

   logic [QB:0]    vld_ff;
   logic [RW-1:0]  rem_ff [QB+1];
   logic [QB-1:0]  low_ff [QB+1];
   logic [QB-1:0]  quo_ff [QB+1];
   logic [DW-1:0]  den_ff [QB+1];
   logic           neg_ff [QB+1];
   logic           ovf_ff [QB+1];
   logic [QB-1:0]  q_fin;
   logic           sat_in;
   logic signed [OW-1:0] q_in;
   logic           out_vld_ff;
   logic           out_sat_ff;
   logic signed [OW-1:0] out_q_ff;

   // Entry: a quotient of 2^QB or more can only saturate.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= RW'(in_n[NW-1:QB]);
      low_ff[0] <= in_n[QB-1:0];
      quo_ff[0] <= '0;
      den_ff[0] <= in_d;
      neg_ff[0] <= in_neg;
      ovf_ff[0] <= (DW'(in_n[NW-1:QB]) >= in_d);
   end

   for (genvar k = 1; k <= QB; k++) begin : g_step
      logic [RW-1:0] sh;
      logic          ge;

      assign sh = {rem_ff[k-1][RW-2:0], low_ff[k-1][QB-1]};
      assign ge = (sh >= RW'(den_ff[k-1]));

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= ge ? (sh - RW'(den_ff[k-1])) : sh;
         low_ff[k] <= {low_ff[k-1][QB-2:0], 1'b0};
         quo_ff[k] <= {quo_ff[k-1][QB-2:0], ge};
         den_ff[k] <= den_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
      end
   end

   // Apply sign and clamp: a negative magnitude may reach 2^31, a positive
   // one must stay below it.
   always_comb begin
      q_fin = quo_ff[QB];
      if (neg_ff[QB]) begin
         sat_in = ovf_ff[QB] || (q_fin > QB'({1'b1, {(OW-1){1'b0}}}));
         q_in   = sat_in ? OUT_MIN : $signed(-q_fin[OW-1:0]);
      end else begin
         sat_in = ovf_ff[QB] || (q_fin[QB-1:OW-1] != '0);
         q_in   = sat_in ? OUT_MAX : $signed(q_fin[OW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      out_q_ff   <= q_in;
      out_sat_ff <= sat_in;
   end

   assign out_valid = out_vld_ff;
   assign out_q     = out_q_ff;
   assign out_sat   = out_sat_ff;

endmodule

`default_nettype wire

/* design/ccc_checker.sv */
// ----------------------------------------------------------------------------
// ccc_checker
// Port-level checks on the circumcenter core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ccc_checker import ccc_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic signed [OW-1:0] rsp_center_x,
   input logic signed [OW-1:0] rsp_center_y,
   input logic signed [OW-1:0] rsp_center_z,
   input logic                 rsp_degenerate,
   input logic                 rsp_saturated
);

   logic at_origin;
   logic x_bound, y_bound, z_bound;

   assign at_origin = (rsp_center_x == '0) && (rsp_center_y == '0) &&
                      (rsp_center_z == '0);
   assign x_bound   = (rsp_center_x == OUT_MAX) || (rsp_center_x == OUT_MIN);
   assign y_bound   = (rsp_center_y == OUT_MAX) || (rsp_center_y == OUT_MIN);
   assign z_bound   = (rsp_center_z == OUT_MAX) || (rsp_center_z == OUT_MIN);

   // Every result beat traces back to a request a fixed latency earlier.
   `ASSERT_IMPLIES(a_rsp_has_req, clock, reset, rsp_valid, $past(start, RSP_LAT))

   // A degenerate triangle reports the origin.
   `ASSERT_IMPLIES(a_deg_zero, clock, reset, rsp_valid && rsp_degenerate, at_origin)

   // A clamped result must show a bound on some axis.
   `ASSERT_IMPLIES(a_sat_bound, clock, reset, rsp_valid && rsp_saturated, x_bound || y_bound || z_bound)

   // Degenerate and saturated never come together.
   `ASSERT_NEVER(a_deg_not_sat, clock, reset, rsp_valid && rsp_degenerate && rsp_saturated)

endmodule

bind triangle_circumcenter_core ccc_checker u_ccc_checker (.*);

`default_nettype wire

/* tb/tb_triangle_circumcenter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_circumcenter_core
// Self-checking bench for the streaming triangle circumcenter core.
// ----------------------------------------------------------------------------
// A queue of triangles is filled per phase and fed by a negedge driver with
// random sender gaps. Every accepted beat is run through a local wide-integer
// predictor of the barycentric circumcenter. Every strobed result is checked
// field by field against the oldest prediction. Phases step through all mode
// values, and a mode write is done only once the pipeline has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_triangle_circumcenter_core;
   import ccc_pkg::*;

   typedef struct packed {
      coord_type ax, ay, az, bx, by, bz, cx, cy, cz;
   } triangle_t;

   typedef struct packed {
      logic signed [OW-1:0] x, y, z;
      logic                 deg, sat;
   } center_t;

   logic                 clock, reset, start, busy;
   coord_type            req_a_x, req_a_y, req_a_z, req_b_x, req_b_y, req_b_z;
   coord_type            req_c_x, req_c_y, req_c_z;
   logic                 csr_write_en;
   logic [MODE_W-1:0]    csr_write_data;
   logic                 rsp_valid, rsp_degenerate, rsp_saturated;
   logic signed [OW-1:0] rsp_center_x, rsp_center_y, rsp_center_z;

   triangle_circumcenter_core dut (.*);

   triangle_t         tri_pending[$];   // triangles waiting to be offered
   center_t           center_expected[$];
   logic [MODE_W-1:0] mode_shadow;      // mirror of the mode register
   int                idle_pct;
   logic              hold_off;         // park the sender until drained
   logic              took;             // a beat was taken at the last edge
   int                err_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Round |num/den| to nearest (ties away), restore sign, clamp to 32 bits.
   function automatic logic signed [OW-1:0] round_coord(
         input logic signed [127:0] num, input logic signed [127:0] den,
         inout logic sat);
      logic         neg;
      logic [127:0] an, ad, q;
      neg = num[127] ^ den[127];
      an  = num[127] ? -num : num;
      ad  = den[127] ? -den : den;
      q   = ((an << 1) + ad) / (ad << 1);
      if (!neg) begin
         if (q > 128'h7FFF_FFFF) begin
            sat = 1'b1;
            return OUT_MAX;
         end
         return q[OW-1:0];
      end
      if (q > 128'h8000_0000) begin
         sat = 1'b1;
         return OUT_MIN;
      end
      return -q[OW-1:0];
   endfunction

   function automatic center_t predict_center(input triangle_t t,
                                              input logic [MODE_W-1:0] mode);
      logic signed [127:0] v[3][3];
      logic signed [127:0] la, lb, lc, d0, d1, d2, wa, wb, wc, den, num;
      logic signed [OW-1:0] res[3];
      int                  dims;
      logic                sat;
      center_t             r;
      dims = (mode == MODE_2D) ? 2 : 3;
      v[0][0] = t.ax; v[0][1] = t.ay; v[0][2] = t.az;
      v[1][0] = t.bx; v[1][1] = t.by; v[1][2] = t.bz;
      v[2][0] = t.cx; v[2][1] = t.cy; v[2][2] = t.cz;
      la = 0; lb = 0; lc = 0;
      for (int i = 0; i < dims; i++) begin
         d0 = v[1][i] - v[2][i];
         d1 = v[2][i] - v[0][i];
         d2 = v[0][i] - v[1][i];
         la += d0 * d0;
         lb += d1 * d1;
         lc += d2 * d2;
      end
      wa  = la * (lb + lc - la);
      wb  = lb * (la + lc - lb);
      wc  = lc * (la + lb - lc);
      den = wa + wb + wc;
      sat = 1'b0;
      res[0] = '0; res[1] = '0; res[2] = '0;
      r.deg = (den == 0);
      if (!r.deg) begin
         for (int i = 0; i < dims; i++) begin
            num    = wa * v[0][i] + wb * v[1][i] + wc * v[2][i];
            res[i] = round_coord(num, den, sat);
         end
      end
      r.x = res[0]; r.y = res[1]; r.z = res[2];
      r.sat = sat;
      return r;
   endfunction

   // Driver: advance the queue on a taken beat, then offer the next one.
   always @(negedge clock) begin
      if (took && tri_pending.size() > 0) tri_pending.pop_front();
      if (!reset && !hold_off && tri_pending.size() > 0 &&
          $urandom_range(99) >= idle_pct) begin
         start   <= 1'b1;
         req_a_x <= tri_pending[0].ax; req_a_y <= tri_pending[0].ay;
         req_a_z <= tri_pending[0].az; req_b_x <= tri_pending[0].bx;
         req_b_y <= tri_pending[0].by; req_b_z <= tri_pending[0].bz;
         req_c_x <= tri_pending[0].cx; req_c_y <= tri_pending[0].cy;
         req_c_z <= tri_pending[0].cz;
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: predict on each taken beat, check each strobed result.
   always @(posedge clock) begin
      triangle_t t;
      center_t   e;
      took <= !reset && start && !busy;
      if (!reset && start && !busy) begin
         t = '{req_a_x, req_a_y, req_a_z, req_b_x, req_b_y, req_b_z,
               req_c_x, req_c_y, req_c_z};
         center_expected.push_back(predict_center(t, mode_shadow));
      end
      if (!reset && rsp_valid) begin
         if (center_expected.size() == 0) begin
            $error("result beat with nothing expected");
            err_count++;
         end else begin
            e = center_expected.pop_front();
            if (rsp_center_x !== e.x) begin
               $error("center_x exp %0d got %0d", e.x, rsp_center_x);
               err_count++;
            end
            if (rsp_center_y !== e.y) begin
               $error("center_y exp %0d got %0d", e.y, rsp_center_y);
               err_count++;
            end
            if (rsp_center_z !== e.z) begin
               $error("center_z exp %0d got %0d", e.z, rsp_center_z);
               err_count++;
            end
            if (rsp_degenerate !== e.deg) begin
               $error("degenerate exp %0b got %0b", e.deg, rsp_degenerate);
               err_count++;
            end
            if (rsp_saturated !== e.sat) begin
               $error("saturated exp %0b got %0b", e.sat, rsp_saturated);
               err_count++;
            end
         end
      end
   end

   function automatic coord_type rand_coord(input int span);
      if (span >= 32768) return coord_type'($urandom());
      return coord_type'($signed($urandom_range(2 * span)) - span);
   endfunction

   function automatic triangle_t rand_triangle();
      triangle_t t;
      int        kind, span;
      kind = $urandom_range(9);
      span = (kind < 4) ? 32768 : (kind < 7) ? 2048 : 64;
      t = '{rand_coord(span), rand_coord(span), rand_coord(span),
            rand_coord(span), rand_coord(span), rand_coord(span),
            rand_coord(span), rand_coord(span), rand_coord(span)};
      // repeat a vertex or line up all three for degenerate cases
      if (kind == 8) begin
         t.cx = t.ax; t.cy = t.ay; t.cz = t.az;
      end else if (kind == 9) begin
         t.bx = t.ax + 16'sd3; t.by = t.ay + 16'sd5; t.bz = t.az - 16'sd7;
         t.cx = t.ax + 16'sd6; t.cy = t.ay + 16'sd10; t.cz = t.az - 16'sd14;
      end
      return t;
   endfunction

   task automatic wait_drained();
      while (tri_pending.size() > 0 || center_expected.size() > 0 || start)
         @(posedge clock);
      repeat (RSP_LAT + 4) @(posedge clock);
   endtask

   localparam coord_type PMAX = 16'sh7FFF;
   localparam coord_type NMAX = -16'sh8000;

   initial begin
      logic [MODE_W-1:0] modes[6];
      int                pcts[6];
      modes = '{MODE_RESET, MODE_2D, 2'd0, 2'd1, MODE_2D, MODE_RESET};
      pcts  = '{0, 46, 21, 0, 46, 21};
      reset = 1'b1; start = 1'b0; csr_write_en = 1'b0; csr_write_data = '0;
      {req_a_x, req_a_y, req_a_z, req_b_x, req_b_y, req_b_z,
       req_c_x, req_c_y, req_c_z} = '0;
      mode_shadow = MODE_RESET; idle_pct = 0; hold_off = 1'b0;
      took = 1'b0; err_count = 0;
      repeat (12) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // directed: zero, extremes, simple shapes, collinear, far centers
      tri_pending.push_back('0);
      tri_pending.push_back('{PMAX, PMAX, PMAX, NMAX, NMAX, NMAX, PMAX, NMAX, PMAX});
      tri_pending.push_back('{NMAX, PMAX, NMAX, PMAX, NMAX, PMAX, NMAX, NMAX, PMAX});
      tri_pending.push_back('{NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, NMAX});
      tri_pending.push_back('{0, 0, 0, 256, 0, 0, 0, 256, 0});
      tri_pending.push_back('{0, 0, 0, 512, 0, 0, 256, 443, 0});
      tri_pending.push_back('{-256, -256, 100, 256, -256, -100, 0, 300, 7});
      tri_pending.push_back('{0, 0, 0, 256, 256, 256, 512, 512, 512});
      tri_pending.push_back('{NMAX, 0, 0, PMAX, 0, 0, 0, 1, 0});
      tri_pending.push_back('{NMAX, NMAX, 0, PMAX, PMAX, 0, 0, 1, 0});
      tri_pending.push_back('{1, 0, 0, -1, 0, 0, 0, 1, 0});
      tri_pending.push_back('{1, 1, 5, 1, 1, -5, 2, 3, 0});
      tri_pending.push_back('{100, 200, PMAX, 100, 200, NMAX, 300, 50, 0});
      tri_pending.push_back('{-3, -3, -3, -3, -3, -3, 9, 9, 9});

      for (int p = 0; p < 6; p++) begin
         wait_drained();
         @(negedge clock);
         csr_write_en <= 1'b1; csr_write_data <= modes[p];
         mode_shadow  = modes[p];
         @(negedge clock);
         csr_write_en <= 1'b0; csr_write_data <= ~modes[p];
         idle_pct = pcts[p];
         for (int n = 0; n < 150; n++) begin
            tri_pending.push_back(rand_triangle());
            // once per phase, park the sender until the pipe is empty
            if (n == 75) begin
               while (tri_pending.size() > 0) @(posedge clock);
               @(negedge clock) hold_off = 1'b1;
               while (center_expected.size() > 0) @(posedge clock);
               @(negedge clock) hold_off = 1'b0;
            end
         end
      end
      wait_drained();
      if (err_count == 0) $display("tb_triangle_circumcenter_core: clean");
      else $display("tb_triangle_circumcenter_core: errors");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #(12 * 400000);
      $display("tb_triangle_circumcenter_core: errors");
      $finish;
   end

endmodule

`default_nettype wire

/* triangle_circumcenter_core.f */
+incdir+design
design/ccc_pkg.sv
design/ccc_front.sv
design/ccc_numer.sv
design/ccc_div.sv
design/triangle_circumcenter_core.sv
design/ccc_checker.sv
tb/tb_triangle_circumcenter_core.sv
